/* hw/rtl/ght_pkg.sv */
// ght_pkg: types, command codes and reset values shared by the
// greenhouse threshold controller modules. No dependencies.
`timescale 1ns / 1ps

package ght_pkg;

  // actuator bit positions, shared by levels and locks
  localparam int unsigned BIT_HEATER = 0;
  localparam int unsigned BIT_COVER  = 1;
  localparam int unsigned BIT_FAN    = 2;
  localparam int unsigned BIT_PUMP   = 3;

  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned SCALE_SHIFT = 3;  // value byte * 8

  typedef logic [7:0]         byte_t;
  typedef logic [9:0]         adc_t;
  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic [1:0]         arm_t;
  typedef logic [1:0]         led_t;
  typedef logic [3:0]         act_t;

  // command bytes
  localparam byte_t CMD_HEAT_ON   = 8'h48;  // H
  localparam byte_t CMD_HEAT_OFF  = 8'h68;  // h
  localparam byte_t CMD_COVER_ON  = 8'h43;  // C
  localparam byte_t CMD_COVER_OFF = 8'h63;  // c
  localparam byte_t CMD_FAN_ON    = 8'h46;  // F
  localparam byte_t CMD_FAN_OFF   = 8'h66;  // f
  localparam byte_t CMD_PUMP_ON   = 8'h57;  // W
  localparam byte_t CMD_PUMP_OFF  = 8'h77;  // w
  localparam byte_t CMD_SOIL_LO   = 8'h73;  // s
  localparam byte_t CMD_SOIL_HI   = 8'h53;  // S
  localparam byte_t CMD_LIGHT_LO  = 8'h62;  // b
  localparam byte_t CMD_LIGHT_HI  = 8'h42;  // B
  localparam byte_t CMD_TEMP_LO   = 8'h74;  // t
  localparam byte_t CMD_TEMP_HI   = 8'h54;  // T

  // arm codes
  localparam arm_t ARM_NONE = 2'd0;
  localparam arm_t ARM_LO   = 2'd1;
  localparam arm_t ARM_HI   = 2'd2;

  // LED codes
  localparam led_t LED_GREEN  = 2'd0;
  localparam led_t LED_YELLOW = 2'd1;
  localparam led_t LED_RED    = 2'd2;

  typedef struct packed {
    act_t   levels;
    act_t   locks;
    arm_t   soil_arm;
    arm_t   light_arm;
    arm_t   temp_arm;
    limit_t soil_lo;
    limit_t soil_hi;
    limit_t light_lim;
    limit_t temp_lo;
    limit_t temp_hi;
  } ght_state_t;

  localparam ght_state_t STATE_RESET = '{
    levels:    4'd0,
    locks:     4'd0,
    soil_arm:  ARM_NONE,
    light_arm: ARM_NONE,
    temp_arm:  ARM_NONE,
    soil_lo:   11'd500,
    soil_hi:   11'd800,
    light_lim: 11'd700,
    temp_lo:   11'd16,
    temp_hi:   11'd30
  };

  typedef struct packed {
    logic  cmd_valid;
    byte_t cmd_byte;
    adc_t  light_a;
    adc_t  light_b;
    adc_t  soil_level;
    logic signed [7:0] temperature;
  } ght_item_t;

  typedef struct packed {
    logic cover_open;
    logic pump_on;
    logic fan_on;
    logic heater_on;
    led_t moisture_led;
    act_t lock_flags;
  } ght_result_t;

endpackage

/* hw/rtl/ght_cmd.sv */
// ght_cmd: command step. Decodes the optional command byte into manual
// actuator actions, threshold arming and threshold writes. Uses ght_pkg.
`timescale 1ns / 1ps

module ght_cmd (
  input  ght_pkg::ght_state_t st,
  input  logic                cmd_valid,
  input  ght_pkg::byte_t      cmd_byte,
  output ght_pkg::ght_state_t st_cmd
);
  import ght_pkg::*;

  logic   man_hit;
  logic   man_on;
  act_t   man_mask;
  limit_t value;

  assign value = {cmd_byte, {SCALE_SHIFT{1'b0}}};

  always_comb begin
    man_hit  = 1'b0;
    man_on   = 1'b0;
    man_mask = '0;
    st_cmd   = st;
    if (cmd_valid) begin
      case (cmd_byte)
        CMD_HEAT_ON:   begin man_hit = 1'b1; man_on = 1'b1; man_mask[BIT_HEATER] = 1'b1; end
        CMD_HEAT_OFF:  begin man_hit = 1'b1; man_mask[BIT_HEATER] = 1'b1; end
        CMD_COVER_ON:  begin man_hit = 1'b1; man_on = 1'b1; man_mask[BIT_COVER] = 1'b1; end
        CMD_COVER_OFF: begin man_hit = 1'b1; man_mask[BIT_COVER] = 1'b1; end
        CMD_FAN_ON:    begin man_hit = 1'b1; man_on = 1'b1; man_mask[BIT_FAN] = 1'b1; end
        CMD_FAN_OFF:   begin man_hit = 1'b1; man_mask[BIT_FAN] = 1'b1; end
        CMD_PUMP_ON:   begin man_hit = 1'b1; man_on = 1'b1; man_mask[BIT_PUMP] = 1'b1; end
        CMD_PUMP_OFF:  begin man_hit = 1'b1; man_mask[BIT_PUMP] = 1'b1; end
        CMD_SOIL_LO:   st_cmd.soil_arm  = ARM_LO;
        CMD_SOIL_HI:   st_cmd.soil_arm  = ARM_HI;
        CMD_LIGHT_LO:  st_cmd.light_arm = ARM_LO;
        CMD_LIGHT_HI:  st_cmd.light_arm = ARM_HI;
        CMD_TEMP_LO:   st_cmd.temp_arm  = ARM_LO;
        CMD_TEMP_HI:   st_cmd.temp_arm  = ARM_HI;
        default: begin
          // value byte: load every armed limit; arm code 3 is left alone
          if (st.temp_arm == ARM_LO) begin
            st_cmd.temp_lo  = value;
            st_cmd.temp_arm = ARM_NONE;
          end else if (st.temp_arm == ARM_HI) begin
            st_cmd.temp_hi  = value;
            st_cmd.temp_arm = ARM_NONE;
          end
          if (st.light_arm == ARM_LO || st.light_arm == ARM_HI) begin
            st_cmd.light_lim = value;
            st_cmd.light_arm = ARM_NONE;
          end
          if (st.soil_arm == ARM_LO) begin
            st_cmd.soil_lo  = value;
            st_cmd.soil_arm = ARM_NONE;
          end else if (st.soil_arm == ARM_HI) begin
            st_cmd.soil_hi  = value;
            st_cmd.soil_arm = ARM_NONE;
          end
        end
      endcase
    end
    if (man_hit) begin
      if ((st.locks & man_mask) != '0) begin
        // already locked: just release
        st_cmd.locks = st.locks & ~man_mask;
      end else begin
        st_cmd.levels = man_on ? (st.levels | man_mask) : (st.levels & ~man_mask);
        st_cmd.locks  = st.locks | man_mask;
      end
    end
  end

endmodule

/* hw/rtl/ght_auto.sv */
// ght_auto: automatic step. Compares the readings against the limits and
// drives every unlocked actuator; builds the result beat. Uses ght_pkg.
`timescale 1ns / 1ps

module ght_auto (
  input  ght_pkg::ght_state_t  st_cmd,
  input  ght_pkg::adc_t        light_a,
  input  ght_pkg::adc_t        light_b,
  input  ght_pkg::adc_t        soil_level,
  input  logic signed [7:0]    temperature,
  output ght_pkg::ght_state_t  st_nxt,
  output ght_pkg::ght_result_t res
);
  import ght_pkg::*;

  act_t  want;
  led_t  led;
  logic  temp_hot;
  logic  temp_mid;
  logic signed [LIMIT_W:0] temp_ext;

  // signed reading against unsigned limits, one bit wider
  assign temp_ext = (LIMIT_W + 1)'(temperature);
  assign temp_hot = temp_ext >= $signed({1'b0, st_cmd.temp_hi});
  assign temp_mid = temp_ext >= $signed({1'b0, st_cmd.temp_lo});

  always_comb begin
    want = '0;
    want[BIT_COVER] = ({1'b0, light_a} >= st_cmd.light_lim) &&
                      ({1'b0, light_b} >= st_cmd.light_lim);
    if ({1'b0, soil_level} < st_cmd.soil_lo) begin
      led = LED_GREEN;
    end else if ({1'b0, soil_level} < st_cmd.soil_hi) begin
      led = LED_YELLOW;
    end else begin
      led = LED_RED;
      want[BIT_PUMP] = 1'b1;
    end
    if (temp_hot) begin
      want[BIT_FAN] = 1'b1;
    end else if (!temp_mid) begin
      want[BIT_HEATER] = 1'b1;
    end
    st_nxt        = st_cmd;
    st_nxt.levels = (st_cmd.levels & st_cmd.locks) | (want & ~st_cmd.locks);
  end

  assign res.cover_open   = st_nxt.levels[BIT_COVER];
  assign res.pump_on      = st_nxt.levels[BIT_PUMP];
  assign res.fan_on       = st_nxt.levels[BIT_FAN];
  assign res.heater_on    = st_nxt.levels[BIT_HEATER];
  assign res.moisture_led = led;
  assign res.lock_flags   = st_nxt.locks;

endmodule

/* hw/rtl/greenhouse_threshold_controller.sv */
// Top level: input register, command and automatic steps, state and
// result register. Uses ght_pkg, ght_cmd and ght_auto.
//
//   channel | direction | handshake          | beat
//   in_     | input     | in_valid/in_stall   | command byte + four readings
//   out_    | output    | out_valid/out_stall | actuator levels, LED, locks
//
// One beat per cycle sustained while out_stall is low; an accepted beat reaches
// the outputs through the input register, then the result register.
// State advances as a beat moves from the input register to the result register.
// rst_n (synchronous) clears levels, locks, arms and restores default limits.
// A stalled result holds; the input register keeps one beat meanwhile.
`timescale 1ns / 1ps

module greenhouse_threshold_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd_valid,
  input  ght_pkg::byte_t    in_cmd_byte,
  input  ght_pkg::adc_t     in_light_a,
  input  ght_pkg::adc_t     in_light_b,
  input  ght_pkg::adc_t     in_soil_level,
  input  logic signed [7:0] in_temperature,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_cover_open,
  output logic              out_pump_on,
  output logic              out_fan_on,
  output logic              out_heater_on,
  output ght_pkg::led_t     out_moisture_led,
  output ght_pkg::act_t     out_lock_flags
);
  import ght_pkg::*;

  ght_item_t   item_r;
  logic        item_valid_r;
  ght_state_t  state_r;
  ght_state_t  st_cmd;
  ght_state_t  state_nxt;
  ght_result_t res_nxt;
  ght_result_t res_r;
  logic        res_valid_r;
  logic        out_free;
  logic        advance;
  logic        in_fire;

  assign out_free = !res_valid_r || !out_stall;
  assign advance  = item_valid_r && out_free;
  assign in_stall = item_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  ght_cmd u_cmd (
    .st        (state_r),
    .cmd_valid (item_r.cmd_valid),
    .cmd_byte  (item_r.cmd_byte),
    .st_cmd    (st_cmd)
  );

  ght_auto u_auto (
    .st_cmd      (st_cmd),
    .light_a     (item_r.light_a),
    .light_b     (item_r.light_b),
    .soil_level  (item_r.soil_level),
    .temperature (item_r.temperature),
    .st_nxt      (state_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
      state_r      <= STATE_RESET;
    end else begin
      if (in_fire) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        res_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.cmd_valid   <= in_cmd_valid;
      item_r.cmd_byte    <= in_cmd_byte;
      item_r.light_a     <= in_light_a;
      item_r.light_b     <= in_light_b;
      item_r.soil_level  <= in_soil_level;
      item_r.temperature <= in_temperature;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = res_valid_r;
  assign out_cover_open   = res_r.cover_open;
  assign out_pump_on      = res_r.pump_on;
  assign out_fan_on       = res_r.fan_on;
  assign out_heater_on    = res_r.heater_on;
  assign out_moisture_led = res_r.moisture_led;
  assign out_lock_flags   = res_r.lock_flags;

endmodule

/* verif/tb_greenhouse_threshold_controller.sv */
`timescale 1ns / 1ps
// tb_greenhouse_threshold_controller: self-checking bench for the greenhouse
// threshold controller. A shadow model predicts every result beat.
// Depends on ght_pkg and greenhouse_threshold_controller.

module tb_greenhouse_threshold_controller;
  import ght_pkg::*;

  localparam int unsigned N_RANDOM     = 1500;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic              in_cmd_valid   = 1'b0;
  byte_t             in_cmd_byte    = '0;
  adc_t              in_light_a     = '0;
  adc_t              in_light_b     = '0;
  adc_t              in_soil_level  = '0;
  logic signed [7:0] in_temperature = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic              out_cover_open;
  logic              out_pump_on;
  logic              out_fan_on;
  logic              out_heater_on;
  led_t              out_moisture_led;
  act_t              out_lock_flags;

  ght_state_t  shadow;
  ght_item_t   pending_ticks[$];
  ght_result_t expected_results[$];
  ght_item_t   cur_tick;

  byte_t manual_cmds [8] = '{CMD_HEAT_ON, CMD_HEAT_OFF, CMD_COVER_ON, CMD_COVER_OFF,
                             CMD_FAN_ON, CMD_FAN_OFF, CMD_PUMP_ON, CMD_PUMP_OFF};
  // temperature arms last, see value picking below
  byte_t arm_cmds [6] = '{CMD_SOIL_LO, CMD_SOIL_HI, CMD_LIGHT_LO, CMD_LIGHT_HI,
                          CMD_TEMP_LO, CMD_TEMP_HI};

  int unsigned n_sent     = 0;
  int unsigned n_checked  = 0;
  int unsigned n_errors   = 0;
  int unsigned n_cmds     = 0;
  int unsigned n_writes   = 0;
  int unsigned cycles     = 0;

  greenhouse_threshold_controller uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd_valid     (in_cmd_valid),
    .in_cmd_byte      (in_cmd_byte),
    .in_light_a       (in_light_a),
    .in_light_b       (in_light_b),
    .in_soil_level    (in_soil_level),
    .in_temperature   (in_temperature),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cover_open   (out_cover_open),
    .out_pump_on      (out_pump_on),
    .out_fan_on       (out_fan_on),
    .out_heater_on    (out_heater_on),
    .out_moisture_led (out_moisture_led),
    .out_lock_flags   (out_lock_flags)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------- shadow model ----------------

  function automatic void set_level(int unsigned b, logic on);
    if (!shadow.locks[b]) shadow.levels[b] = on;
  endfunction

  function automatic void manual_override(int unsigned b, logic on);
    if (shadow.locks[b]) begin
      shadow.locks[b] = 1'b0;
    end else begin
      set_level(b, on);
      shadow.locks[b] = 1'b1;
    end
  endfunction

  function automatic void write_limits(byte_t value);
    limit_t v;
    v = {value, 3'b000};
    if (shadow.temp_arm != ARM_NONE || shadow.light_arm != ARM_NONE ||
        shadow.soil_arm != ARM_NONE) n_writes++;
    if (shadow.temp_arm == ARM_LO) begin
      shadow.temp_lo = v;
      shadow.temp_arm = ARM_NONE;
    end else if (shadow.temp_arm == ARM_HI) begin
      shadow.temp_hi = v;
      shadow.temp_arm = ARM_NONE;
    end
    // light has a single limit; either arm code selects it
    if (shadow.light_arm == ARM_LO || shadow.light_arm == ARM_HI) begin
      shadow.light_lim = v;
      shadow.light_arm = ARM_NONE;
    end
    if (shadow.soil_arm == ARM_LO) begin
      shadow.soil_lo = v;
      shadow.soil_arm = ARM_NONE;
    end else if (shadow.soil_arm == ARM_HI) begin
      shadow.soil_hi = v;
      shadow.soil_arm = ARM_NONE;
    end
  endfunction

  function automatic ght_result_t greenhouse_tick(ght_item_t it);
    ght_result_t r;
    int temp_c;
    int lo;
    int hi;
    if (it.cmd_valid) begin
      n_cmds++;
      case (it.cmd_byte)
        CMD_HEAT_ON:   manual_override(BIT_HEATER, 1'b1);
        CMD_HEAT_OFF:  manual_override(BIT_HEATER, 1'b0);
        CMD_COVER_ON:  manual_override(BIT_COVER, 1'b1);
        CMD_COVER_OFF: manual_override(BIT_COVER, 1'b0);
        CMD_FAN_ON:    manual_override(BIT_FAN, 1'b1);
        CMD_FAN_OFF:   manual_override(BIT_FAN, 1'b0);
        CMD_PUMP_ON:   manual_override(BIT_PUMP, 1'b1);
        CMD_PUMP_OFF:  manual_override(BIT_PUMP, 1'b0);
        CMD_SOIL_LO:   shadow.soil_arm = ARM_LO;
        CMD_SOIL_HI:   shadow.soil_arm = ARM_HI;
        CMD_LIGHT_LO:  shadow.light_arm = ARM_LO;
        CMD_LIGHT_HI:  shadow.light_arm = ARM_HI;
        CMD_TEMP_LO:   shadow.temp_arm = ARM_LO;
        CMD_TEMP_HI:   shadow.temp_arm = ARM_HI;
        default:       write_limits(it.cmd_byte);
      endcase
    end

    set_level(BIT_COVER, it.light_a >= shadow.light_lim && it.light_b >= shadow.light_lim);

    if (it.soil_level < shadow.soil_lo) begin
      r.moisture_led = LED_GREEN;
      set_level(BIT_PUMP, 1'b0);
    end else if (it.soil_level < shadow.soil_hi) begin
      r.moisture_led = LED_YELLOW;
      set_level(BIT_PUMP, 1'b0);
    end else begin
      r.moisture_led = LED_RED;
      set_level(BIT_PUMP, 1'b1);
    end

    // signed reading against unsigned limits
    temp_c = $signed(it.temperature);
    lo = int'(shadow.temp_lo);
    hi = int'(shadow.temp_hi);
    if (temp_c >= hi) begin
      set_level(BIT_FAN, 1'b1);
      set_level(BIT_HEATER, 1'b0);
    end else if (temp_c >= lo) begin
      set_level(BIT_FAN, 1'b0);
      set_level(BIT_HEATER, 1'b0);
    end else begin
      set_level(BIT_FAN, 1'b0);
      set_level(BIT_HEATER, 1'b1);
    end

    r.cover_open = shadow.levels[BIT_COVER];
    r.pump_on    = shadow.levels[BIT_PUMP];
    r.fan_on     = shadow.levels[BIT_FAN];
    r.heater_on  = shadow.levels[BIT_HEATER];
    r.lock_flags = shadow.locks;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic adc_t any_reading();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return adc_t'($urandom_range(1023));
    endcase
  endfunction

  function automatic logic signed [7:0] any_temp();
    case ($urandom_range(9))
      0:             return -8'sd128;
      1:             return 8'sd127;
      2, 3, 4, 5, 6: return 8'(int'($urandom_range(70)) - 10);
      default:       return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void queue_tick(logic cv, byte_t cb, adc_t la, adc_t lb, adc_t soil,
                                     logic signed [7:0] temp);
    ght_item_t it;
    it.cmd_valid   = cv;
    it.cmd_byte    = cb;
    it.light_a     = la;
    it.light_b     = lb;
    it.soil_level  = soil;
    it.temperature = temp;
    pending_ticks.push_back(it);
  endfunction

  // quiet window in mid-run: no idling on either side
  function automatic bit take_break();
    if (n_sent >= 600 && n_sent < 900) return 1'b0;
    return $urandom_range(99) < 38;
  endfunction

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(greenhouse_tick(cur_tick));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_ticks.size() != 0 && !take_break()) begin
          cur_tick = pending_ticks.pop_front();
          in_cmd_valid   <= cur_tick.cmd_valid;
          in_cmd_byte    <= cur_tick.cmd_byte;
          in_light_a     <= cur_tick.light_a;
          in_light_b     <= cur_tick.light_b;
          in_soil_level  <= cur_tick.soil_level;
          in_temperature <= cur_tick.temperature;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    ght_result_t got;
    ght_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.cover_open   = out_cover_open;
        got.pump_on      = out_pump_on;
        got.fan_on       = out_fan_on;
        got.heater_on    = out_heater_on;
        got.moisture_led = out_moisture_led;
        got.lock_flags   = out_lock_flags;
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: result beat with nothing expected", $realtime);
        end else begin
          want = expected_results.pop_front();
          if (want.cover_open !== got.cover_open || want.pump_on !== got.pump_on ||
              want.fan_on !== got.fan_on || want.heater_on !== got.heater_on ||
              want.moisture_led !== got.moisture_led ||
              want.lock_flags !== got.lock_flags) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
              $display("%0t: beat %0d exp cover=%b pump=%b fan=%b heat=%b led=%0d locks=%b",
                       $realtime, n_checked, want.cover_open, want.pump_on, want.fan_on,
                       want.heater_on, want.moisture_led, want.lock_flags);
              $display("%0t: beat %0d got cover=%b pump=%b fan=%b heat=%b led=%0d locks=%b",
                       $realtime, n_checked, got.cover_open, got.pump_on, got.fan_on,
                       got.heater_on, got.moisture_led, got.lock_flags);
            end
          end
        end
        n_checked++;
      end
      out_stall <= take_break();
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout: %0d beats sent, %0d checked, %0d still expected",
               n_sent, n_checked, expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    int unsigned n_queued;
    int unsigned sel;
    int unsigned arm_idx;
    byte_t value;

    shadow.levels    = '0;
    shadow.locks     = '0;
    shadow.soil_arm  = ARM_NONE;
    shadow.light_arm = ARM_NONE;
    shadow.temp_arm  = ARM_NONE;
    shadow.soil_lo   = 11'd500;
    shadow.soil_hi   = 11'd800;
    shadow.light_lim = 11'd700;
    shadow.temp_lo   = 11'd16;
    shadow.temp_hi   = 11'd30;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: rails, every manual action (lock then unlock), a held lock,
    // re-arm, multi-arm write, crossed limits, unarmed value byte
    queue_tick(1'b0, 8'h00, '0, '0, '0, -8'sd128);
    queue_tick(1'b1, 8'hFF, '1, '1, '1, 8'sd127);
    for (int i = 0; i < 8; i++)
      queue_tick(1'b1, manual_cmds[i], any_reading(), any_reading(), any_reading(), any_temp());
    queue_tick(1'b1, CMD_PUMP_OFF, any_reading(), any_reading(), 10'd0, any_temp());
    queue_tick(1'b0, 8'h00, any_reading(), any_reading(), '1, any_temp());
    queue_tick(1'b1, CMD_PUMP_ON, any_reading(), any_reading(), '1, any_temp());
    queue_tick(1'b1, CMD_SOIL_LO, any_reading(), any_reading(), any_reading(), any_temp());
    queue_tick(1'b1, CMD_SOIL_HI, any_reading(), any_reading(), any_reading(), any_temp());
    queue_tick(1'b1, CMD_LIGHT_LO, any_reading(), any_reading(), any_reading(), any_temp());
    queue_tick(1'b1, CMD_TEMP_LO, any_reading(), any_reading(), any_reading(), any_temp());
    queue_tick(1'b1, 8'h05, any_reading(), any_reading(), any_reading(), any_temp());
    queue_tick(1'b0, 8'h00, 10'd40, 10'd39, 10'd600, 8'sd35);
    queue_tick(1'b0, 8'h00, 10'd40, 10'd40, 10'd10, 8'sd20);
    queue_tick(1'b1, CMD_LIGHT_HI, any_reading(), any_reading(), any_reading(), any_temp());
    queue_tick(1'b1, CMD_TEMP_HI, any_reading(), any_reading(), any_reading(), any_temp());
    queue_tick(1'b1, 8'hFF, '1, '1, any_reading(), 8'sd127);
    queue_tick(1'b1, CMD_SOIL_LO, any_reading(), any_reading(), any_reading(), any_temp());
    queue_tick(1'b1, 8'h00, any_reading(), any_reading(), 10'd0, any_temp());

    // hold off until the pipe is empty
    while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);

    n_queued = 0;
    while (n_queued < N_RANDOM) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        // no command this tick; the byte lines carry junk
        queue_tick(1'b0, byte_t'($urandom_range(255)), any_reading(), any_reading(),
                   any_reading(), any_temp());
        n_queued++;
      end else if (sel < 60) begin
        queue_tick(1'b1, manual_cmds[$urandom_range(7)], any_reading(), any_reading(),
                   any_reading(), any_temp());
        n_queued++;
      end else if (sel < 88) begin
        // arm then value, sometimes a second arm or a plain tick in between
        arm_idx = $urandom_range(5);
        queue_tick(1'b1, arm_cmds[arm_idx], any_reading(), any_reading(),
                   any_reading(), any_temp());
        n_queued++;
        if ($urandom_range(3) == 0) begin
          queue_tick(1'b1, arm_cmds[$urandom_range(5)], any_reading(), any_reading(),
                     any_reading(), any_temp());
          n_queued++;
        end
        if ($urandom_range(4) == 0) begin
          queue_tick(1'b0, byte_t'($urandom_range(255)), any_reading(), any_reading(),
                     any_reading(), any_temp());
          n_queued++;
        end
        if ($urandom_range(9) == 0)
          value = byte_t'($urandom_range(255));
        else if (arm_idx >= 4)
          value = byte_t'($urandom_range(15));
        else
          value = byte_t'($urandom_range(127));
        queue_tick(1'b1, value, any_reading(), any_reading(), any_reading(), any_temp());
        n_queued++;
      end else if (sel < 95) begin
        queue_tick(1'b1, byte_t'($urandom_range(255)), any_reading(), any_reading(),
                   any_reading(), any_temp());
        n_queued++;
      end else begin
        // dangling arm, left for a later value byte
        queue_tick(1'b1, arm_cmds[$urandom_range(5)], any_reading(), any_reading(),
                   any_reading(), any_temp());
        n_queued++;
      end
    end

    while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) n_errors++;

    $display("covered %0d ticks, %0d with a command byte, %0d threshold writes",
             n_sent, n_cmds, n_writes);
    $display("checked %0d result beats, %0d failures", n_checked, n_errors);
    if (n_errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ght_pkg.sv
hw/rtl/ght_cmd.sv
hw/rtl/ght_auto.sv
hw/rtl/greenhouse_threshold_controller.sv
verif/tb_greenhouse_threshold_controller.sv
